@@ design/tac_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tac_pkg
// Shared types and constants for the tile attachment check block.
// ----------------------------------------------------------------------------
package tac_pkg;

  // input kinds; kind 3 behaves as a read
  localparam logic [1:0] KIND_ATTACH = 2'd0;
  localparam logic [1:0] KIND_WRITE  = 2'd1;
  localparam logic [1:0] KIND_READ   = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_TEMPERATURE = 2'd0;
  localparam logic [1:0] REG_GLUE_STR    = 2'd1;
  localparam logic [1:0] REG_SIDES_LOW   = 2'd2;
  localparam logic [1:0] REG_SIDES_HIGH  = 2'd3;

  localparam logic [5:0]  TEMPERATURE_RST = 6'd2;
  localparam logic [31:0] GLUE_STR_RST    = 32'd0;
  localparam logic [63:0] SIDES_RST       = {64{1'b1}};

  // side codes: 0 N, 1 E, 2 S, 3 W
  // neighbour order: west, south, east, north
  localparam logic [1:0] OWN_SIDE [4] = '{2'd3, 2'd2, 2'd1, 2'd0};
  localparam logic [1:0] NB_SIDE  [4] = '{2'd1, 2'd0, 2'd3, 2'd2};

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_RDC,
    S_CHK,
    S_NB,
    S_DEC,
    S_RESP
  } state_e;

  typedef struct packed {
    logic [63:0] sides_lo;
    logic [63:0] sides_hi;
    logic [31:0] glue_str;
  } tac_cfg_t;

  typedef struct packed {
    logic [2:0] tile;
    logic [1:0] dir;
    logic [3:0] nb_value;
    logic       nb_in;
  } tac_bond_req_t;

endpackage

@@ design/tac_bond_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tac_bond_unit
// Glue match for one neighbour: looks up both facing glues and returns the
// strength the neighbour adds, or zero.
// ----------------------------------------------------------------------------
module tac_bond_unit import tac_pkg::*; #(
  parameter int GLUE_TYPES = 8
) (
  input  tac_cfg_t      cfg_i,
  input  tac_bond_req_t req_i,
  output logic [3:0]    strength_o
);

  logic [2:0]  nb_tile;
  logic [63:0] own_word;
  logic [63:0] nb_word;
  logic [3:0]  own_glue;
  logic [3:0]  nb_glue;
  logic        own_ok;
  logic [3:0]  str;

  assign nb_tile  = 3'(req_i.nb_value - 4'd1);
  assign own_word = req_i.tile[2] ? cfg_i.sides_hi : cfg_i.sides_lo;
  assign nb_word  = nb_tile[2] ? cfg_i.sides_hi : cfg_i.sides_lo;

  assign own_glue = own_word[{req_i.tile[1:0], OWN_SIDE[req_i.dir], 2'b00} +: 4];
  assign nb_glue  = nb_word[{nb_tile[1:0], NB_SIDE[req_i.dir], 2'b00} +: 4];

  // nibbles of 8 and above, or past the glue count, carry no glue
  assign own_ok = (own_glue < 4'(GLUE_TYPES)) && !own_glue[3];
  assign str    = cfg_i.glue_str[{own_glue[2:0], 2'b00} +: 4];

  always_comb begin
    strength_o = 4'd0;
    if (req_i.nb_in && (req_i.nb_value != 4'd0) && own_ok && (own_glue == nb_glue)) begin
      strength_o = str;
    end
  end

endmodule

@@ design/tile_attachment_check.sv @@
`timescale 1ns / 1ps
// Attempt on an empty cell: centre read, four neighbour reads through the one read
// port with the shared glue unit, decide. Write, read and attempt on an occupied
// cell or bad tile: centre read, plus the write for a write; off the grid: none.
// The response holds while the output stalls. One item at a time.
// Reset: a clearing pass writes every cell empty, one per cycle, GRID_SIDE*GRID_SIDE
// cells (1024 by default), during which no item is taken; config writes still land.
// ----------------------------------------------------------------------------
// tile_attachment_check
// Tile grid with attachment check against the configured temperature.
// ----------------------------------------------------------------------------
module tile_attachment_check import tac_pkg::*; #(
  parameter int GRID_SIDE  = 32,
  parameter int NUM_TILES  = 8,
  parameter int GLUE_TYPES = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [63:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  kind_i,
  input  logic [4:0]  col_i,
  input  logic [4:0]  row_i,
  input  logic [2:0]  tile_i,
  input  logic        make_empty_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        placed_o,
  output logic [3:0]  cell_value_o,
  output logic [5:0]  bond_strength_o
);

  localparam int DEPTH = GRID_SIDE * GRID_SIDE;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PW    = AW + 5;

  state_e state_q, state_d;

  logic [5:0]    temp_q;
  tac_cfg_t      cfg_q;
  logic [AW-1:0] clr_q;

  logic [1:0] kind_q;
  logic [4:0] col_q;
  logic [4:0] row_q;
  logic [2:0] tile_q;
  logic       mempty_q;
  logic [2:0] idx_q;
  logic       nb_in_q;
  logic [5:0] bond_q;
  logic       placed_q;
  logic [3:0] cell_q;

  logic [3:0]    mem_q [DEPTH];
  logic [3:0]    rdata_q;
  logic          mem_re;
  logic          mem_we;
  logic [AW-1:0] raddr;
  logic [AW-1:0] waddr;
  logic [3:0]    wdata;

  logic          accept;
  logic          out_grid;
  logic          tile_ok;
  logic [3:0]    tile_val;
  logic [3:0]    wr_val;
  logic [PW-1:0] prod;
  logic [AW-1:0] centre;
  logic [AW-1:0] nb_addr [4];
  logic [3:0]    nb_ok;
  logic [3:0]    strength;
  tac_bond_req_t req;

  assign accept   = in_valid_i && !in_stall_o;
  assign out_grid = ({4'd0, col_i} >= 9'(GRID_SIDE)) || ({4'd0, row_i} >= 9'(GRID_SIDE));
  assign tile_ok  = {1'b0, tile_q} < 4'(NUM_TILES);
  assign tile_val = {1'b0, tile_q} + 4'd1;
  assign wr_val   = mempty_q ? 4'd0 : (tile_ok ? tile_val : rdata_q);

  assign prod   = PW'(col_q) * PW'(GRID_SIDE) + PW'(row_q);
  assign centre = prod[AW-1:0];

  assign nb_addr[0] = centre - AW'(GRID_SIDE);
  assign nb_addr[1] = centre - AW'(1);
  assign nb_addr[2] = centre + AW'(GRID_SIDE);
  assign nb_addr[3] = centre + AW'(1);

  assign nb_ok[0] = (col_q != 5'd0);
  assign nb_ok[1] = (row_q != 5'd0);
  assign nb_ok[2] = (({4'd0, col_q} + 9'd1) < 9'(GRID_SIDE));
  assign nb_ok[3] = (({4'd0, row_q} + 9'd1) < 9'(GRID_SIDE));

  assign req.tile     = tile_q;
  assign req.dir      = 2'(idx_q - 3'd1);
  assign req.nb_value = rdata_q;
  assign req.nb_in    = nb_in_q;

  tac_bond_unit #(
    .GLUE_TYPES(GLUE_TYPES)
  ) u_bond (
    .cfg_i     (cfg_q),
    .req_i     (req),
    .strength_o(strength)
  );

  // grid memory
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[waddr] <= wdata;
    end
    if (mem_re) begin
      rdata_q <= mem_q[raddr];
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: begin
        if (clr_q == AW'(DEPTH - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (accept) state_d = out_grid ? S_RESP : S_RDC;
      end
      S_RDC: state_d = S_CHK;
      S_CHK: begin
        if ((kind_q == KIND_ATTACH) && (rdata_q == 4'd0) && tile_ok) begin
          state_d = S_NB;
        end else begin
          state_d = S_RESP;
        end
      end
      S_NB: begin
        if (idx_q == 3'd4) state_d = S_DEC;
      end
      S_DEC: state_d = S_RESP;
      S_RESP: begin
        if (!out_stall_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // outputs and memory control
  always_comb begin
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    mem_re      = 1'b0;
    mem_we      = 1'b0;
    raddr       = centre;
    waddr       = centre;
    wdata       = 4'd0;
    case (state_q)
      S_CLEAR: begin
        mem_we = 1'b1;
        waddr  = clr_q;
      end
      S_IDLE: in_stall_o = 1'b0;
      S_RDC:  mem_re = 1'b1;
      S_CHK: begin
        if (kind_q == KIND_ATTACH) begin
          mem_re = nb_ok[0];
          raddr  = nb_addr[0];
        end else if (kind_q == KIND_WRITE) begin
          mem_we = 1'b1;
          wdata  = wr_val;
        end
      end
      S_NB: begin
        if (idx_q != 3'd4) begin
          mem_re = nb_ok[idx_q[1:0]];
          raddr  = nb_addr[idx_q[1:0]];
        end
      end
      S_DEC: begin
        mem_we = (bond_q >= temp_q);
        wdata  = tile_val;
      end
      S_RESP: out_valid_o = 1'b1;
      default: in_stall_o = 1'b1;
    endcase
  end

  // control state and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      clr_q        <= '0;
      temp_q       <= TEMPERATURE_RST;
      cfg_q.glue_str <= GLUE_STR_RST;
      cfg_q.sides_lo <= SIDES_RST;
      cfg_q.sides_hi <= SIDES_RST;
    end else begin
      state_q <= state_d;
      if (state_q == S_CLEAR) begin
        clr_q <= clr_q + AW'(1);
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_TEMPERATURE: temp_q         <= cfg_wdata_i[5:0];
          REG_GLUE_STR:    cfg_q.glue_str <= cfg_wdata_i[31:0];
          REG_SIDES_LOW:   cfg_q.sides_lo <= cfg_wdata_i;
          REG_SIDES_HIGH:  cfg_q.sides_hi <= cfg_wdata_i;
          default:         temp_q         <= temp_q;
        endcase
      end
    end
  end

  // item datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          kind_q   <= kind_i;
          col_q    <= col_i;
          row_q    <= row_i;
          tile_q   <= tile_i;
          mempty_q <= make_empty_i;
          placed_q <= 1'b0;
          bond_q   <= 6'd0;
          cell_q   <= 4'd0;
        end
      end
      S_CHK: begin
        idx_q   <= 3'd1;
        nb_in_q <= nb_ok[0];
        case (kind_q)
          KIND_ATTACH: cell_q <= rdata_q;
          KIND_WRITE:  cell_q <= wr_val;
          default:     cell_q <= rdata_q;
        endcase
      end
      S_NB: begin
        // fold in the neighbour read last cycle, fetch the next
        bond_q <= bond_q + 6'(strength);
        if (idx_q != 3'd4) begin
          nb_in_q <= nb_ok[idx_q[1:0]];
          idx_q   <= idx_q + 3'd1;
        end
      end
      S_DEC: begin
        if (bond_q >= temp_q) begin
          placed_q <= 1'b1;
          cell_q   <= tile_val;
        end
      end
      default: idx_q <= idx_q;
    endcase
  end

  assign placed_o        = placed_q;
  assign cell_value_o    = cell_q;
  assign bond_strength_o = bond_q;

endmodule
